// ===== sv/car_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cumulative ack receiver: step codes of the control program,
// jump conditions, the control word layout, the program table and register indexes.
// Depends on nothing; used by cumulative_ack_receiver_top.
package car_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned SeqW   = 15;
  localparam int unsigned DrawW  = 7;
  localparam int unsigned WinW   = 8;
  localparam int unsigned TotW   = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOTAL_MESSAGES = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DROP_PERCENT   = 2'd2;

  // Register reset values.
  localparam logic [WinW-1:0] WINDOW_SIZE_RST    = 8'd30;
  localparam logic [TotW-1:0] TOTAL_MESSAGES_RST = 16'd20000;
  localparam logic [PctW-1:0] DROP_PERCENT_RST   = 7'd0;

  // Program step addresses.
  typedef enum logic [2:0] {
    STEP_CLEAR = 3'd0,
    STEP_WAIT  = 3'd1,
    STEP_CHECK = 3'd2,
    STEP_PRIME = 3'd3,
    STEP_SCAN  = 3'd4,
    STEP_DROP  = 3'd5,
    STEP_EMIT  = 3'd6
  } step_e;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_CLR_MORE  = 3'd0,
    COND_NO_XFER   = 3'd1,
    COND_OUT_RANGE = 3'd2,
    COND_WIN_EMPTY = 3'd3,
    COND_SCAN_END  = 3'd4,
    COND_SUPPRESS  = 3'd5,
    COND_OUT_BUSY  = 3'd6
  } cond_e;

  // One control word: datapath enables, then a condition that selects jump over next.
  typedef struct packed {
    logic  clear;   // write a zero at the clear counter
    logic  accept;  // offer tready on the input side
    logic  load;    // mark the sequence number, load scan index and window end
    logic  scan;    // evaluate map data, advance scan index
    logic  emit;    // load the output register and move the window start
    cond_e cond;
    step_e jump;
    step_e next;
  } ctrl_t;

  // Control program.
  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{clear: 1'b0, accept: 1'b0, load: 1'b0, scan: 1'b0, emit: 1'b0,
          cond: COND_NO_XFER, jump: STEP_WAIT, next: STEP_WAIT};
    case (step)
      STEP_CLEAR: begin
        w.clear = 1'b1;
        w.cond  = COND_CLR_MORE;
        w.jump  = STEP_CLEAR;
        w.next  = STEP_WAIT;
      end
      STEP_WAIT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_XFER;
        w.jump   = STEP_WAIT;
        w.next   = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.load = 1'b1;
        w.cond = COND_OUT_RANGE;
        w.jump = STEP_WAIT;
        w.next = STEP_PRIME;
      end
      STEP_PRIME: begin
        w.cond = COND_WIN_EMPTY;
        w.jump = STEP_DROP;
        w.next = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan = 1'b1;
        w.cond = COND_SCAN_END;
        w.jump = STEP_DROP;
        w.next = STEP_SCAN;
      end
      STEP_DROP: begin
        w.cond = COND_SUPPRESS;
        w.jump = STEP_WAIT;
        w.next = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.jump = STEP_EMIT;
        w.next = STEP_WAIT;
      end
      default: begin
        w.cond = COND_NO_XFER;
        w.jump = STEP_WAIT;
        w.next = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/cumulative_ack_receiver_top.sv =====
`timescale 1ns / 1ps
// Cumulative ack receiver: a microcoded sequencer over a received-map memory.
// Each accepted item is checked, then the map is scanned one entry per cycle from the window
// start: no entries when the window is empty, else 1 up to window_size + 1.
// A new item is taken only once the previous one's ack is emitted or dropped; an item with an
// out-of-range sequence number returns straight to waiting after the check step.
// A finished ack waits in an output register. Reset clears the control registers and loads the
// register defaults; the map is then zeroed entry by entry, no input taken.
module cumulative_ack_receiver_top #(
  parameter int unsigned SEQ_SPACE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [car_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [car_pkg::CfgW-1:0]       cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [14:0] seq_number, [21:15] drop_draw, [23:22] zero
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] ack_number, [15] zero
  output logic        m_axis_tlast_o    // all_received
);

  localparam int unsigned AW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam logic [AW-1:0] ClrLast = AW'(SEQ_SPACE - 1);

  // Configuration registers.
  logic [car_pkg::WinW-1:0] win_size_q;
  logic [car_pkg::TotW-1:0] total_q;
  logic [car_pkg::PctW-1:0] drop_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= car_pkg::WINDOW_SIZE_RST;
      total_q    <= car_pkg::TOTAL_MESSAGES_RST;
      drop_pct_q <= car_pkg::DROP_PERCENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        car_pkg::REG_WINDOW_SIZE:    win_size_q <= cfg_data_i[car_pkg::WinW-1:0];
        car_pkg::REG_TOTAL_MESSAGES: total_q    <= cfg_data_i;
        car_pkg::REG_DROP_PERCENT:   drop_pct_q <= cfg_data_i[car_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and control word.
  car_pkg::step_e pc_q, pc_d;
  car_pkg::ctrl_t cw;
  logic           cond_hit;

  // Datapath registers.
  logic [AW-1:0]              clr_q, clr_d;
  logic [car_pkg::SeqW-1:0]   seq_q, seq_d;
  logic [car_pkg::DrawW-1:0]  draw_q, draw_d;
  logic [car_pkg::TotW-1:0]   idx_q, idx_d;
  logic [car_pkg::TotW-1:0]   wend_q, wend_d;
  logic [car_pkg::SeqW-1:0]   lio_q, lio_d;
  logic [car_pkg::SeqW-1:0]   ws_q, ws_d;
  logic                       out_vld_q, out_vld_d;
  logic [car_pkg::SeqW-1:0]   ack_q, ack_d;
  logic                       all_q, all_d;

  // Shared combinational terms.
  logic [car_pkg::TotW-1:0] tot;
  logic [car_pkg::TotW-1:0] tot_m1;
  logic [car_pkg::TotW-1:0] win_sum;
  logic                     out_range;
  logic                     out_busy;
  logic                     in_xfer;
  logic                     emit_fire;

  // Received map memory.
  logic          map_mem [SEQ_SPACE];
  logic          map_we;
  logic [AW-1:0] map_wa;
  logic          map_wd;
  logic [AW-1:0] map_ra;
  logic          map_rd_q;

  // Effective total, window end candidates and handshake terms.
  always_comb begin
    if (32'(total_q) < SEQ_SPACE) begin
      tot = total_q;
    end else begin
      tot = car_pkg::TotW'(SEQ_SPACE);
    end
    tot_m1    = tot - car_pkg::TotW'(1);
    win_sum   = {1'b0, ws_q} + car_pkg::TotW'(win_size_q);
    out_range = {1'b0, seq_q} >= tot;
    out_busy  = out_vld_q && !m_axis_tready_i;
    in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  end

  // Control word fetch.
  always_comb begin
    cw = car_pkg::ucode(pc_q);
  end

  // Condition select.
  always_comb begin
    case (cw.cond)
      car_pkg::COND_CLR_MORE:  cond_hit = (clr_q != ClrLast);
      car_pkg::COND_NO_XFER:   cond_hit = !in_xfer;
      car_pkg::COND_OUT_RANGE: cond_hit = out_range;
      car_pkg::COND_WIN_EMPTY: cond_hit = ({1'b0, ws_q} > wend_q);
      car_pkg::COND_SCAN_END:  cond_hit = !map_rd_q || (idx_q == wend_q);
      car_pkg::COND_SUPPRESS:  cond_hit = (draw_q < drop_pct_q);
      car_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
      default:                 cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    pc_d = cond_hit ? cw.jump : cw.next;
  end

  // Step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= car_pkg::STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Handshake outputs and memory port controls.
  always_comb begin
    s_axis_tready_o = cw.accept;
    emit_fire       = cw.emit && !out_busy;
    map_we          = cw.clear || (cw.load && !out_range);
    map_wa          = cw.clear ? clr_q : AW'(seq_q);
    map_wd          = !cw.clear;
    map_ra          = cw.scan ? AW'(idx_q + car_pkg::TotW'(1)) : AW'(idx_q);
  end

  // Datapath next values.
  always_comb begin
    clr_d     = clr_q;
    seq_d     = seq_q;
    draw_d    = draw_q;
    idx_d     = idx_q;
    wend_d    = wend_q;
    lio_d     = lio_q;
    ws_d      = ws_q;
    out_vld_d = out_vld_q;
    ack_d     = ack_q;
    all_d     = all_q;

    if (cw.clear) begin
      clr_d = clr_q + AW'(1);
    end
    if (in_xfer) begin
      seq_d  = s_axis_tdata_i[car_pkg::SeqW-1:0];
      draw_d = s_axis_tdata_i[car_pkg::SeqW +: car_pkg::DrawW];
    end
    // Start of scan: index at the window start, end clamped to the last message.
    if (cw.load) begin
      idx_d  = {1'b0, ws_q};
      wend_d = (win_sum > tot_m1) ? tot_m1 : win_sum;
    end
    // One map entry per cycle; a received entry moves the in-order mark.
    if (cw.scan) begin
      if (map_rd_q) begin
        lio_d = idx_q[car_pkg::SeqW-1:0];
      end
      idx_d = idx_q + car_pkg::TotW'(1);
    end
    // Output register: taken by the sink, then reloaded by a new ack.
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (emit_fire) begin
      out_vld_d = 1'b1;
      ack_d     = lio_q;
      all_d     = ({1'b0, lio_q} == tot_m1);
      ws_d      = lio_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      lio_q     <= '0;
      ws_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      lio_q     <= lio_d;
      ws_q      <= ws_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    draw_q <= draw_d;
    idx_q  <= idx_d;
    wend_q <= wend_d;
    ack_q  <= ack_d;
    all_q  <= all_d;
  end

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_ra];
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, ack_q};
  assign m_axis_tlast_o  = all_q;

  // The scan index never runs past the clamped window end.
  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == car_pkg::STEP_SCAN) |-> (idx_q <= wend_q))
    else $error("scan index beyond window end");

  // The window start never overtakes the in-order mark.
  a_ws_le_lio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_q <= lio_q)
    else $error("window start ahead of last in-order number");

  // An out-of-range sequence number returns straight to waiting.
  a_ignore_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == car_pkg::STEP_CHECK && out_range) |=> (pc_q == car_pkg::STEP_WAIT))
    else $error("out-of-range item not dropped");

endmodule

// ===== sim/tb_cumulative_ack_receiver_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_ack_receiver_top. Directed and random
// message streams are checked against an in-bench model of the ack receiver.
// Depends on car_pkg and cumulative_ack_receiver_top; reads no files.
module tb_cumulative_ack_receiver_top;

  localparam int unsigned SEQ_SPACE     = 32768;
  localparam int unsigned RUN_PHASES    = 12;
  localparam int unsigned RUN_ITEMS     = 140;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_AT       = 120;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CALM_FROM     = 400;
  localparam int unsigned CALM_TO       = 800;
  localparam int unsigned CYCLE_LIMIT   = 2500000;

  typedef struct packed {
    logic [car_pkg::SeqW-1:0] ack_number;
    logic                     all_received;
  } ack_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [car_pkg::CfgIdxW-1:0] cfg_idx_i = car_pkg::REG_WINDOW_SIZE;
  logic [car_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [23:0]                 s_axis_tdata_i = '0;  // [14:0] seq_number, [21:15] drop_draw,
                                                     // [23:22] zero
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [15:0]                 m_axis_tdata_o;       // [14:0] ack_number, [15] zero
  logic                        m_axis_tlast_o;       // all_received

  // Shadow copy of the receiver state and its registers.
  bit                       got_map [SEQ_SPACE];
  bit [car_pkg::SeqW-1:0]   in_order_top = '0;
  bit [car_pkg::SeqW-1:0]   win_start = '0;
  bit [car_pkg::WinW-1:0]   win_size = car_pkg::WINDOW_SIZE_RST;
  bit [car_pkg::TotW-1:0]   msg_total = car_pkg::TOTAL_MESSAGES_RST;
  bit [car_pkg::PctW-1:0]   drop_pct = car_pkg::DROP_PERCENT_RST;

  ack_t            acks_due[$];
  logic [23:0]     msg_q[$];
  int unsigned     msgs_queued = 0;
  int unsigned     msgs_taken = 0;
  int unsigned     acks_seen = 0;
  int unsigned     err_cnt = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     hold_left = 0;
  int unsigned     cursor = 0;
  bit              held = 1'b0;
  bit              in_took = 1'b0;
  logic            calm;

  cumulative_ack_receiver_top #(.SEQ_SPACE(SEQ_SPACE)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Neither side idles at random while this stretch of messages is taken.
  assign calm = (msgs_taken >= CALM_FROM) && (msgs_taken < CALM_TO);

  function automatic int unsigned eff_total(input bit [car_pkg::TotW-1:0] tot);
    return (tot < SEQ_SPACE) ? tot : SEQ_SPACE;
  endfunction

  // Marks one message received, rescans the window and tells whether an ack goes out.
  function automatic bit receive_message(input logic [car_pkg::SeqW-1:0] seq_no,
                                         input logic [car_pkg::DrawW-1:0] draw,
                                         output ack_t ack);
    int unsigned tot;
    int unsigned wend;
    ack = '0;
    tot = eff_total(msg_total);
    if (seq_no >= tot) return 1'b0;
    got_map[seq_no] = 1'b1;
    wend = win_start + win_size;
    if (wend > tot - 1) wend = tot - 1;
    for (int unsigned i = win_start; i <= wend; i++) begin
      if (!got_map[i]) break;
      in_order_top = car_pkg::SeqW'(i);
    end
    if (draw < drop_pct) return 1'b0;
    win_start = in_order_top;
    ack.ack_number = in_order_top;
    ack.all_received = (in_order_top == tot - 1);
    return 1'b1;
  endfunction

  // Mostly in-range draws, now and then the full 7-bit range.
  function automatic int unsigned pick_draw();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 99);
  endfunction

  task automatic push_msg(input int unsigned seq_no, input int unsigned draw);
    msg_q.push_back({2'b00, draw[car_pkg::DrawW-1:0], seq_no[car_pkg::SeqW-1:0]});
    msgs_queued++;
  endtask

  // Waits until every message is taken and every ack has come, then lets the scan finish.
  task automatic drain();
    while (msgs_taken != msgs_queued || acks_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(input bit [car_pkg::WinW-1:0] ws, input bit [car_pkg::TotW-1:0] tot,
                          input bit [car_pkg::PctW-1:0] pct);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= car_pkg::REG_WINDOW_SIZE;
    cfg_data_i <= {{(car_pkg::CfgW-car_pkg::WinW){1'b0}}, ws};
    @(negedge clk_i);
    cfg_idx_i <= car_pkg::REG_TOTAL_MESSAGES;
    cfg_data_i <= tot;
    @(negedge clk_i);
    cfg_idx_i <= car_pkg::REG_DROP_PERCENT;
    cfg_data_i <= {{(car_pkg::CfgW-car_pkg::PctW){1'b0}}, pct};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queues a stream with n in-range messages: shuffled runs of new numbers,
  // retransmits of recent ones and random noise over the whole sequence space.
  task automatic queue_run(input int unsigned n, input int unsigned tot);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned top;
    int unsigned lo;
    int unsigned j;
    int unsigned tmp;
    int unsigned run_seq [8];
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      top = (cursor < tot) ? cursor : tot;
      if (pick < 75 && cursor < tot) begin
        len = $urandom_range(1, 8);
        if (len > tot - cursor) len = tot - cursor;
        for (int k = 0; k < len; k++) run_seq[k] = cursor + k;
        for (int k = len - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = run_seq[k];
          run_seq[k] = run_seq[j];
          run_seq[j] = tmp;
        end
        for (int k = 0; k < len; k++) push_msg(run_seq[k], pick_draw());
        cursor += len;
        sent += len;
      end else if (pick < 92 && top > 0) begin
        lo = (top > 40) ? top - 40 : 0;
        push_msg($urandom_range(lo, top - 1), pick_draw());
        sent++;
      end else begin
        tmp = $urandom_range(0, SEQ_SPACE - 1);
        push_msg(tmp, pick_draw());
        if (tmp < tot) sent++;
      end
    end
  endtask

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_cumulative_ack_receiver_top: errors");
      $finish;
    end
  end

  // Sender: offers the next queued message once the current one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else if (!s_axis_tvalid_i || in_took) begin
      if (msg_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= msg_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while messages keep coming.
  // The hold-off starts while most acks go out, so the output register fills.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (!held && acks_seen >= HOLD_AT && msg_q.size() > 20 && drop_pct < 50) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Monitor: tracks register writes, predicts on each input transfer and
  // checks each output transfer against the oldest pending ack.
  always @(posedge clk_i) begin
    ack_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          car_pkg::REG_WINDOW_SIZE:    win_size = cfg_data_i[car_pkg::WinW-1:0];
          car_pkg::REG_TOTAL_MESSAGES: msg_total = cfg_data_i[car_pkg::TotW-1:0];
          car_pkg::REG_DROP_PERCENT:   drop_pct = cfg_data_i[car_pkg::PctW-1:0];
          default: ;
        endcase
      end
      in_took = s_axis_tvalid_i && s_axis_tready_o;
      if (in_took) begin
        msgs_taken++;
        if (receive_message(s_axis_tdata_i[car_pkg::SeqW-1:0],
                            s_axis_tdata_i[car_pkg::SeqW +: car_pkg::DrawW], want))
          acks_due.push_back(want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        acks_seen++;
        if (acks_due.size() == 0) begin
          $error("unexpected ack: ack_number %0d, all_received %0b",
                 m_axis_tdata_o[car_pkg::SeqW-1:0], m_axis_tlast_o);
          err_cnt++;
        end else begin
          want = acks_due.pop_front();
          if (m_axis_tdata_o[car_pkg::SeqW-1:0] !== want.ack_number) begin
            $error("ack_number: expected %0d, got %0d", want.ack_number,
                   m_axis_tdata_o[car_pkg::SeqW-1:0]);
            err_cnt++;
          end
          if (m_axis_tlast_o !== want.all_received) begin
            $error("all_received: expected %0b, got %0b", want.all_received, m_axis_tlast_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Stimulus: directed corner cases, then random phases under changing settings.
  initial begin
    bit [car_pkg::WinW-1:0] ws_pick;
    bit [car_pkg::TotW-1:0] tot_pick;
    bit [car_pkg::PctW-1:0] pct_pick;
    int unsigned            roll;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first message, a hole, its fill, out of range, a far number.
    push_msg(0, 0);
    push_msg(2, 99);
    push_msg(1, 127);
    push_msg(32767, 0);
    push_msg(19999, 5);
    // Zero window and total beyond the sequence space; draws around the percent.
    set_regs(0, 16'hFFFF, 100);
    push_msg(3, 99);
    push_msg(32767, 100);
    push_msg(4, 127);
    // Widest window, short transfer: a dropped ack, completion, and traffic after it.
    set_regs(255, 5, 127);
    push_msg(3, 126);
    push_msg(4, 127);
    push_msg(0, 127);
    // Total lowered below the window start, so the scan covers nothing.
    set_regs(255, 3, 0);
    push_msg(1, 0);
    push_msg(3, 0);
    // A total of zero ignores everything.
    set_regs(255, 0, 0);
    push_msg(0, 0);
    push_msg(32767, 127);
    cursor = 5;

    for (int p = 0; p < RUN_PHASES; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) ws_pick = 8'd255;
      else if (roll < 35) ws_pick = car_pkg::WinW'($urandom_range(1, 4));
      else ws_pick = car_pkg::WinW'($urandom_range(1, 64));

      roll = $urandom_range(0, 99);
      if (roll < 40) pct_pick = 7'd0;
      else if (roll < 55) pct_pick = car_pkg::PctW'($urandom_range(0, 30));
      else if (roll < 75) pct_pick = car_pkg::PctW'($urandom_range(0, 100));
      else if (roll < 90) pct_pick = 7'd100;
      else pct_pick = 7'd127;

      roll = $urandom_range(0, 99);
      if (roll < 25) tot_pick = 16'd32768;
      else if (roll < 45) tot_pick = 16'hFFFF;
      else if (roll < 75) tot_pick = car_pkg::TotW'(cursor + $urandom_range(20, 200));
      else if (roll < 88) tot_pick = car_pkg::TotW'($urandom_range(1, cursor));
      else tot_pick = car_pkg::TotW'($urandom_range(1, 65535));

      set_regs(ws_pick, tot_pick, pct_pick);
      queue_run(RUN_ITEMS, eff_total(tot_pick));
    end

    drain();
    if (err_cnt == 0) begin
      $display("tb_cumulative_ack_receiver_top: clean");
    end else begin
      $display("tb_cumulative_ack_receiver_top: errors");
    end
    $finish;
  end

endmodule
